### rtl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int GLYPH_W = 8;
    localparam int TAB_W   = 5;
    localparam int CNT_W   = 5;

    localparam logic [GLYPH_W-1:0] CH_NL    = 8'd10;
    localparam logic [GLYPH_W-1:0] CH_CR    = 8'd13;
    localparam logic [GLYPH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [GLYPH_W-1:0] CH_SPACE = 8'd32;

    localparam logic [TAB_W-1:0] MAX_TAB   = 5'd16;
    localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

    // register byte addresses
    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_TAB  = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_NONE
    } t_op_kind;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_STATUS = 2'd2
    } t_cmd;

    typedef struct packed {
        logic             mode;
        logic [TAB_W-1:0] tab_width;
    } t_cfg;

    typedef struct packed {
        t_op_kind           kind;
        logic               bottom;
        logic [GLYPH_W-1:0] glyph;
        logic [CNT_W-1:0]   count;
        logic               eob;
    } t_op;

    typedef struct packed {
        t_cmd               cmd;
        logic [ROW_W-1:0]   phys_row;
        logic [COL_W-1:0]   col;
        logic [GLYPH_W-1:0] glyph;
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
        logic [ROW_W-1:0]   top_row;
        logic               refresh;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

### rtl/tcw_front.sv
// Front end: input handshake and character classification.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
    input  wire tcw_pkg::t_cfg                   i_cfg,
    input  wire                                  i_valid,
    input  wire  [tcw_pkg::GLYPH_W-1:0]          i_char_code,
    input  wire                                  i_end_of_batch,
    input  wire                                  i_q_full,
    output logic                                 o_stall,
    output logic                                 o_push,
    output tcw_pkg::t_op                         o_op
);

    logic [tcw_pkg::TAB_W-1:0] tab_n;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        tab_n = (i_cfg.tab_width > tcw_pkg::MAX_TAB) ? tcw_pkg::MAX_TAB : i_cfg.tab_width;

        o_op.kind   = tcw_pkg::OP_PUT;
        o_op.bottom = i_cfg.mode;
        o_op.glyph  = i_char_code;
        o_op.count  = tcw_pkg::CNT_W'(1);
        o_op.eob    = i_end_of_batch;

        if (i_char_code == tcw_pkg::CH_NL) begin
            o_op.kind = tcw_pkg::OP_NEWLINE;
        end else if (i_char_code == tcw_pkg::CH_CR && !i_cfg.mode) begin
            o_op.kind = tcw_pkg::OP_RETURN;
        end else if (i_char_code == tcw_pkg::CH_TAB) begin
            o_op.glyph = tcw_pkg::CH_SPACE;
            o_op.count = tcw_pkg::CNT_W'(tab_n);
            // zero-width tab writes nothing
            o_op.kind  = (tab_n == '0) ? tcw_pkg::OP_NONE : tcw_pkg::OP_PUT;
        end
    end

endmodule

`default_nettype wire

### rtl/tcw_queue.sv
// Short register queue between the front end and the write sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire tcw_pkg::t_op i_op,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_not_empty,
    output tcw_pkg::t_op      o_op
);

    tcw_pkg::t_op              r_mem [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::Q_AW-1:0]  r_wr;
    logic [tcw_pkg::Q_AW-1:0]  r_rd;
    logic [tcw_pkg::Q_AW:0]    r_cnt;

    assign o_full      = (r_cnt == (tcw_pkg::Q_AW+1)'(tcw_pkg::Q_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_op        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/tcw_back.sv
// Write sequencer: cursor/ring state, one store command per cycle unless stalled, output register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_op_valid,
    input  wire tcw_pkg::t_op i_op,
    output logic              o_pop,
    input  wire               i_stall,
    output logic              o_valid,
    output tcw_pkg::t_result  o_res
);

    localparam int COL_W = tcw_pkg::COL_W;
    localparam int ROW_W = tcw_pkg::ROW_W;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]   COLS_X   = (COL_W+1)'(COLS);
    localparam logic [ROW_W:0]   ROWS_X   = (ROW_W+1)'(ROWS);

    // committed state (after every popped character)
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [COL_W-1:0] r_bot_col, n_bot_col;
    logic [ROW_W-1:0] r_top,     n_top;

    // walking copy used while the words of one character go out
    logic                        r_busy, n_busy;
    logic                        r_bottom, n_bottom;
    logic                        r_status, n_status;
    logic                        r_clr, n_clr;
    logic [tcw_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [COL_W-1:0]            r_w_col, n_w_col;
    logic [ROW_W-1:0]            r_w_row, n_w_row;
    logic [ROW_W-1:0]            r_w_top, n_w_top;
    logic [tcw_pkg::GLYPH_W-1:0] r_glyph, n_glyph;
    logic                        r_eob, n_eob;

    logic             r_out_valid;
    tcw_pkg::t_result r_out;
    tcw_pkg::t_result res;

    logic             step;
    logic [ROW_W-1:0] rr;
    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] phys;
    logic [ROW_W-1:0] w_top_inc;
    logic             at_edge;
    logic             scroll_w;

    logic [COL_W-1:0] base_col;
    logic [COL_W:0]   col_sum;
    logic             col_wrap;
    logic [COL_W-1:0] col_new;
    logic [ROW_W-1:0] top_inc;
    logic             row_last;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // one result word from the walking copy
    always_comb begin
        rr        = r_bottom ? LAST_ROW : r_w_row;
        row_sum   = {1'b0, r_w_top} + {1'b0, rr};
        phys      = (row_sum >= ROWS_X) ? ROW_W'(row_sum - ROWS_X) : row_sum[ROW_W-1:0];
        w_top_inc = (r_w_top == LAST_ROW) ? '0 : r_w_top + 1'b1;
        at_edge   = (r_w_col == LAST_COL);
        scroll_w  = at_edge && (r_bottom || r_w_row == LAST_ROW);

        res.cmd        = tcw_pkg::CMD_STATUS;
        res.phys_row   = '0;
        res.col        = '0;
        res.glyph      = '0;
        res.cursor_col = r_cur_col;
        res.cursor_row = r_cur_row;
        res.top_row    = r_top;
        res.last       = 1'b1;

        n_w_col = r_w_col;
        n_w_row = r_w_row;
        n_w_top = r_w_top;
        n_cnt   = r_cnt;
        n_clr   = r_clr;

        if (r_status) begin
            res.last = 1'b1;
        end else if (r_clr) begin
            res.cmd      = tcw_pkg::CMD_CLEAR;
            res.phys_row = r_w_top;
            res.glyph    = tcw_pkg::CH_SPACE;
            res.last     = (r_cnt == '0);
            n_w_top      = w_top_inc;
            n_clr        = 1'b0;
        end else begin
            res.cmd      = tcw_pkg::CMD_WRITE;
            res.phys_row = phys;
            res.col      = r_w_col;
            res.glyph    = r_glyph;
            res.last     = (r_cnt == tcw_pkg::CNT_W'(1)) && !scroll_w;
            n_cnt        = r_cnt - 1'b1;
            if (at_edge) begin
                n_w_col = '0;
                if (scroll_w) begin
                    n_clr = 1'b1;
                end else begin
                    n_w_row = r_w_row + 1'b1;
                end
            end else begin
                n_w_col = r_w_col + 1'b1;
            end
        end
        res.refresh = r_eob && res.last;
    end

    assign step  = r_busy && (!r_out_valid || !i_stall);
    assign o_pop = i_op_valid && (!r_busy || (step && res.last));

    // committed state after the popped character
    always_comb begin
        base_col = i_op.bottom ? r_bot_col : r_cur_col;
        col_sum  = {1'b0, base_col} + (COL_W+1)'(i_op.count);
        col_wrap = (col_sum >= COLS_X);
        col_new  = col_wrap ? COL_W'(col_sum - COLS_X) : col_sum[COL_W-1:0];
        top_inc  = (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
        row_last = (r_cur_row == LAST_ROW);

        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_bot_col = r_bot_col;
        n_top     = r_top;

        unique case (i_op.kind)
            tcw_pkg::OP_NEWLINE: begin
                if (i_op.bottom) begin
                    n_top     = top_inc;
                    n_bot_col = '0;
                end else begin
                    n_cur_col = '0;
                    if (row_last) begin
                        n_top     = top_inc;
                        n_bot_col = '0;
                    end else begin
                        n_cur_row = r_cur_row + 1'b1;
                    end
                end
            end
            tcw_pkg::OP_RETURN: begin
                n_cur_col = '0;
            end
            tcw_pkg::OP_PUT: begin
                if (i_op.bottom) begin
                    n_bot_col = col_new;
                    if (col_wrap) begin
                        n_top = top_inc;
                    end
                end else begin
                    n_cur_col = col_new;
                    if (col_wrap) begin
                        if (row_last) begin
                            n_top     = top_inc;
                            n_bot_col = '0;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // walking copy: load on pop, else advance on each word
    always_comb begin
        n_busy   = r_busy;
        n_bottom = r_bottom;
        n_status = r_status;
        n_glyph  = r_glyph;
        n_eob    = r_eob;
        if (step && res.last) begin
            n_busy = 1'b0;
        end
        if (o_pop) begin
            n_busy   = 1'b1;
            n_bottom = i_op.bottom;
            n_glyph  = i_op.glyph;
            n_eob    = i_op.eob;
            n_status = (i_op.kind == tcw_pkg::OP_NONE) || (i_op.kind == tcw_pkg::OP_RETURN)
                    || (i_op.kind == tcw_pkg::OP_NEWLINE && !i_op.bottom && !row_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_bot_col   <= '0;
            r_top       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (o_pop) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                r_bot_col <= n_bot_col;
                r_top     <= n_top;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bottom <= n_bottom;
        r_status <= n_status;
        r_glyph  <= n_glyph;
        r_eob    <= n_eob;
        if (step) begin
            r_out <= res;
        end
        if (o_pop) begin
            r_w_col <= base_col;
            r_w_row <= r_cur_row;
            r_w_top <= r_top;
            r_cnt   <= (i_op.kind == tcw_pkg::OP_PUT) ? i_op.count : '0;
            r_clr   <= (i_op.kind == tcw_pkg::OP_NEWLINE) && (i_op.bottom || row_last);
        end else if (step) begin
            r_w_col <= n_w_col;
            r_w_row <= n_w_row;
            r_w_top <= n_w_top;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
        end
    end

endmodule

`default_nettype wire

### rtl/text_console_char_writer.sv
// Text console character writer: character bytes in, character store commands out.
//
// Input channel: i_valid / o_stall carry one character word (i_char_code,
// i_end_of_batch). Output channel: o_valid / i_stall carry one command word
// (write character, clear row, or status only) with the cursor and top row
// as they stand after the whole character. o_last marks the final word of a
// character; o_refresh copies end_of_batch on that word.
// Registers on the APB port: mode at 0x0, tab width at 0x4; the user must
// write them only while the block is idle, which the block does not enforce.
// With the sequencer idle, the first word of a character passes the queue,
// the walking copy and the output register. The write sequencer sends one
// word per cycle while the receiver does not stall: a plain character,
// return or newline gives one word, a tab gives tab_width words (16 at most,
// one status word for a zero width) and a wrap that scrolls adds a row clear.
// A two-word queue lets input be taken while the sequencer works.
// Reset clears the cursor, bottom column and top row and sets tab width 4.
// When the receiver stalls, the output word holds and the queue fills, then
// o_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [tcw_pkg::GLYPH_W-1:0]    i_char_code,
    input  wire                            i_end_of_batch,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [1:0]                     o_cmd,
    output logic [tcw_pkg::ROW_W-1:0]      o_phys_row,
    output logic [tcw_pkg::COL_W-1:0]      o_col,
    output logic [tcw_pkg::GLYPH_W-1:0]    o_glyph,
    output logic [tcw_pkg::COL_W-1:0]      o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tcw_pkg::ROW_W-1:0]      o_top_row,
    output logic                           o_refresh,
    output logic                           o_last,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [2:0]                     paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    tcw_pkg::t_cfg    r_cfg;
    tcw_pkg::t_op     front_op;
    tcw_pkg::t_op     q_op;
    tcw_pkg::t_result res;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_not_empty;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= 1'b0;
            r_cfg.tab_width <= tcw_pkg::TAB_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == tcw_pkg::ADDR_TAB[2]) begin
                r_cfg.tab_width <= pwdata[tcw_pkg::TAB_W-1:0];
            end else begin
                r_cfg.mode <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == tcw_pkg::ADDR_MODE[2]) begin
            prdata = {31'd0, r_cfg.mode};
        end else begin
            prdata = {{(32-tcw_pkg::TAB_W){1'b0}}, r_cfg.tab_width};
        end
    end

    tcw_front u_front (
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .i_char_code    (i_char_code),
        .i_end_of_batch (i_end_of_batch),
        .i_q_full       (q_full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_op           (front_op)
    );

    tcw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (front_op),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_op        (q_op)
    );

    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_not_empty),
        .i_op       (q_op),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_res      (res)
    );

    assign o_cmd        = res.cmd;
    assign o_phys_row   = res.phys_row;
    assign o_col        = res.col;
    assign o_glyph      = res.glyph;
    assign o_cursor_col = res.cursor_col;
    assign o_cursor_row = res.cursor_row;
    assign o_top_row    = res.top_row;
    assign o_refresh    = res.refresh;
    assign o_last       = res.last;

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cmd == tcw_pkg::CMD_STATUS) |-> o_last)
        else $error("status word not marked last");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cmd == tcw_pkg::CMD_WRITE) |->
            (o_phys_row < tcw_pkg::ROW_W'(ROWS) && o_col < tcw_pkg::COL_W'(COLS)))
        else $error("write outside the character store");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_col < tcw_pkg::COL_W'(COLS)
                  && o_cursor_row < tcw_pkg::ROW_W'(ROWS)
                  && o_top_row < tcw_pkg::ROW_W'(ROWS)))
        else $error("cursor or top row out of range");

    a_refresh_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_refresh) |-> o_last)
        else $error("refresh on a word that is not last");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for text_console_char_writer: directed and random character streams.
`timescale 1ns / 1ps

module testbench;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int DRAIN_WAIT  = 8;
    localparam int WATCH_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [tcw_pkg::GLYPH_W-1:0]   i_char_code;
    logic                          i_end_of_batch;
    logic                          o_valid;
    logic                          i_stall;
    logic [1:0]                    o_cmd;
    logic [tcw_pkg::ROW_W-1:0]     o_phys_row;
    logic [tcw_pkg::COL_W-1:0]     o_col;
    logic [tcw_pkg::GLYPH_W-1:0]   o_glyph;
    logic [tcw_pkg::COL_W-1:0]     o_cursor_col;
    logic [tcw_pkg::ROW_W-1:0]     o_cursor_row;
    logic [tcw_pkg::ROW_W-1:0]     o_top_row;
    logic                          o_refresh;
    logic                          o_last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    text_console_char_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_batch (i_end_of_batch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cmd          (o_cmd),
        .o_phys_row     (o_phys_row),
        .o_col          (o_col),
        .o_glyph        (o_glyph),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_top_row      (o_top_row),
        .o_refresh      (o_refresh),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // console state as the block should hold it
    logic                      cfg_mode;
    logic [tcw_pkg::TAB_W-1:0] cfg_tab;
    int                        cur_col;
    int                        cur_row;
    int                        bottom_col;
    int                        top_ptr;

    tcw_pkg::t_result step_words[$];
    tcw_pkg::t_result pending_words[$];

    bit               gaps_on;
    bit               hold_request;
    int               hold_len;
    int               holds_done;
    int               chars_sent;
    int               words_checked;
    int               rows_cleared;
    int               mismatches;
    int               quiet_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ---------------- prediction ----------------

    function automatic void add_word(tcw_pkg::t_cmd cmd, int row, int col,
                                     logic [tcw_pkg::GLYPH_W-1:0] g);
        tcw_pkg::t_result w;
        w          = '0;
        w.cmd      = cmd;
        w.phys_row = tcw_pkg::ROW_W'(row);
        w.col      = tcw_pkg::COL_W'(col);
        w.glyph    = g;
        step_words.push_back(w);
    endfunction

    // the top physical row is cleared and becomes the new bottom row
    function automatic void scroll_screen();
        add_word(tcw_pkg::CMD_CLEAR, top_ptr, 0, tcw_pkg::CH_SPACE);
        top_ptr    = (top_ptr + 1) % ROWS;
        bottom_col = 0;
    endfunction

    function automatic void advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            scroll_screen();
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void put_at_cursor(logic [tcw_pkg::GLYPH_W-1:0] g);
        add_word(tcw_pkg::CMD_WRITE, (top_ptr + cur_row) % ROWS, cur_col, g);
        cur_col++;
        if (cur_col >= COLS) begin
            cur_col = 0;
            advance_row();
        end
    endfunction

    function automatic void put_on_bottom(logic [tcw_pkg::GLYPH_W-1:0] g);
        add_word(tcw_pkg::CMD_WRITE, (top_ptr + ROWS - 1) % ROWS, bottom_col, g);
        bottom_col++;
        if (bottom_col >= COLS)
            scroll_screen();
    endfunction

    // expected command words for one character, appended to pending_words
    function automatic void console_step(logic [tcw_pkg::GLYPH_W-1:0] ch, logic eob);
        int spaces;
        int n;
        step_words.delete();
        spaces = (cfg_tab > tcw_pkg::MAX_TAB) ? int'(tcw_pkg::MAX_TAB) : int'(cfg_tab);
        if (!cfg_mode) begin
            if (ch == tcw_pkg::CH_NL) begin
                cur_col = 0;
                advance_row();
            end else if (ch == tcw_pkg::CH_CR) begin
                cur_col = 0;
            end else if (ch == tcw_pkg::CH_TAB) begin
                repeat (spaces) put_at_cursor(tcw_pkg::CH_SPACE);
            end else begin
                put_at_cursor(ch);
            end
        end else begin
            if (ch == tcw_pkg::CH_NL) begin
                scroll_screen();
            end else if (ch == tcw_pkg::CH_TAB) begin
                repeat (spaces) put_on_bottom(tcw_pkg::CH_SPACE);
            end else begin
                put_on_bottom(ch);
            end
        end
        if (step_words.size() == 0)
            add_word(tcw_pkg::CMD_STATUS, 0, 0, '0);
        n = step_words.size();
        for (int k = 0; k < n; k++) begin
            step_words[k].cursor_col = tcw_pkg::COL_W'(cur_col);
            step_words[k].cursor_row = tcw_pkg::ROW_W'(cur_row);
            step_words[k].top_row    = tcw_pkg::ROW_W'(top_ptr);
            step_words[k].refresh    = (k == n - 1) ? eob : 1'b0;
            step_words[k].last       = (k == n - 1);
            pending_words.push_back(step_words[k]);
        end
    endfunction

    // ---------------- checking ----------------

    function automatic string word_text(tcw_pkg::t_result w);
        string s;
        s = $sformatf("cmd=%0d row=%0d col=%0d glyph=%02h",
                      w.cmd, w.phys_row, w.col, w.glyph);
        return {s, $sformatf(" cursor=%0d/%0d top=%0d refresh=%0b last=%0b",
                             w.cursor_row, w.cursor_col, w.top_row, w.refresh, w.last)};
    endfunction

    tcw_pkg::t_result got_word;
    tcw_pkg::t_result want_word;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_word.cmd        = tcw_pkg::t_cmd'(o_cmd);
            got_word.phys_row   = o_phys_row;
            got_word.col        = o_col;
            got_word.glyph      = o_glyph;
            got_word.cursor_col = o_cursor_col;
            got_word.cursor_row = o_cursor_row;
            got_word.top_row    = o_top_row;
            got_word.refresh    = o_refresh;
            got_word.last       = o_last;
            words_checked++;
            if (got_word.cmd == tcw_pkg::CMD_CLEAR)
                rows_cleared++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected word: %s", $time, word_text(got_word));
            end else begin
                want_word = pending_words.pop_front();
                if (got_word !== want_word) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] word mismatch", $time);
                        $display("    expected: %s", word_text(want_word));
                        $display("    actual:   %s", word_text(got_word));
                    end
                end
            end
        end
    end

    // ---------------- receiver stalls ----------------

    initial begin
        int held;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                // long hold-off so the input queue fills and o_stall rises
                i_stall <= 1'b1;
                for (held = 0; held < hold_len; held++)
                    @(posedge i_clk);
                i_stall <= 1'b0;
                hold_request = 1'b0;
                holds_done++;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles, %0d words outstanding",
                     $time, WATCH_LIMIT, pending_words.size());
            $display("text_console_char_writer test failed");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    task automatic send_char(input logic [tcw_pkg::GLYPH_W-1:0] ch, input logic eob);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_char_code    <= ch;
        i_end_of_batch <= eob;
        do @(posedge i_clk); while (o_stall);
        console_step(ch, eob);
        chars_sent++;
    endtask

    // drop valid and wait until every expected word has come out
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == tcw_pkg::ADDR_MODE)
            cfg_mode = data[0];
        else if (addr == tcw_pkg::ADDR_TAB)
            cfg_tab = data[tcw_pkg::TAB_W-1:0];
    endtask

    task automatic set_console(input logic mode, input int tab);
        write_reg(tcw_pkg::ADDR_MODE, 32'(mode));
        write_reg(tcw_pkg::ADDR_TAB, 32'(tab));
    endtask

    function automatic logic [tcw_pkg::GLYPH_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            return tcw_pkg::CH_NL;
        else if (r < 26)
            return tcw_pkg::CH_CR;
        else if (r < 36)
            return tcw_pkg::CH_TAB;
        return tcw_pkg::GLYPH_W'($urandom_range(0, 255));
    endfunction

    // ---------------- tests ----------------

    // cursor mode at reset settings: plain bytes, return, newline, tab
    task automatic test_cursor_basics();
        send_char("A", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(tcw_pkg::CH_CR, 1'b0);
        send_char(tcw_pkg::CH_NL, 1'b0);
        send_char(tcw_pkg::CH_TAB, 1'b0);
        send_char(8'h7F, 1'b1);
        settle();
    endtask

    // widest tab wraps the line; zero width gives status only; 31 saturates
    task automatic test_tab_widths();
        write_reg(tcw_pkg::ADDR_TAB, 32'd16);
        repeat (4) send_char(tcw_pkg::CH_TAB, 1'b0);
        send_char(tcw_pkg::CH_TAB, 1'b1);
        settle();
        write_reg(tcw_pkg::ADDR_TAB, 32'd0);
        send_char(tcw_pkg::CH_TAB, 1'b1);
        settle();
        write_reg(tcw_pkg::ADDR_TAB, 32'd31);
        send_char(tcw_pkg::CH_TAB, 1'b1);
        settle();
    endtask

    // teletype mode: return is printed, newline scrolls, a full row scrolls
    task automatic test_bottom_line();
        set_console(1'b1, 16);
        send_char("x", 1'b0);
        send_char(tcw_pkg::CH_CR, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(tcw_pkg::CH_NL, 1'b0);
        repeat (5) send_char(tcw_pkg::CH_TAB, 1'b0);
        send_char("y", 1'b1);
        settle();
    endtask

    task automatic test_random_text(input logic mode, input int tab, input int count,
                                    input bit gaps);
        set_console(mode, tab);
        gaps_on = gaps;
        repeat (count) send_char(pick_char(), 1'($urandom_range(0, 3) == 0));
        settle();
        gaps_on = 1'b0;
    endtask

    // receiver stops while tab-heavy text keeps coming
    task automatic test_backpressure();
        set_console(1'b0, 16);
        hold_len     = HOLD_CYCLES;
        hold_request = 1'b1;
        repeat (40)
            send_char(($urandom_range(0, 1) == 0) ? tcw_pkg::CH_TAB : pick_char(),
                      1'($urandom_range(0, 1)));
        settle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_char_code    = '0;
        i_end_of_batch = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        gaps_on        = 1'b0;
        hold_request   = 1'b0;
        hold_len       = 0;
        holds_done     = 0;
        chars_sent     = 0;
        words_checked  = 0;
        rows_cleared   = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        cfg_mode       = 1'b0;
        cfg_tab        = tcw_pkg::TAB_RESET;
        cur_col        = 0;
        cur_row        = 0;
        bottom_col     = 0;
        top_ptr        = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_cursor_basics();
        test_tab_widths();
        test_bottom_line();
        test_random_text(1'b0, 4, 140, 1'b1);
        test_random_text(1'b1, 16, 90, 1'b1);
        test_random_text(1'b0, 1, 70, 1'b1);
        test_backpressure();
        test_random_text(1'b1, 7, 90, 1'b0);

        $display("Sent %0d characters, checked %0d words, %0d row clears, %0d long holds.",
                 chars_sent, words_checked, rows_cleared, holds_done);
        $display("Both console modes, tab widths 0, 1, 4, 7, 16 and 31; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("text_console_char_writer test passed");
        end else begin
            $display("text_console_char_writer test failed");
        end
        $finish;
    end

endmodule
